FILE: hw/rtl/xsbr_pkg.sv
// xsbr_pkg: shared types and constants for the bounded random generator
// no dependencies
package xsbr_pkg;

  localparam int unsigned WordW = 32;

  localparam logic [WordW-1:0] MIX_GAMMA = 32'h9e37_79b9;
  localparam logic [WordW-1:0] MIX_MUL_A = 32'h85eb_ca6b;
  localparam logic [WordW-1:0] MIX_MUL_B = 32'hc2b2_ae35;

  typedef enum logic [3:0] {
    S_SEED_ADD,
    S_SEED_MULA,
    S_SEED_XOR,
    S_SEED_MULB,
    S_SEED_STORE,
    S_IDLE,
    S_SCALE,
    S_REM,
    S_FINISH
  } state_t;

endpackage

FILE: hw/rtl/xoshiro128ss_bounded_random.sv
// xoshiro128ss_bounded_random: xoshiro128** draw reduced into a signed range
// seeding by splitmix32 expansion, bit-serial restoring remainder
// depends on xsbr_pkg
//
//  channel  | direction | payload
//  ---------+-----------+---------------------------------------------
//  s_axis   | in        | tdata[31:0] min_value, tdata[63:32] max_value
//  m_axis   | out       | tdata[31:0] value
//  cfg      | in        | cfg_data[31:0] seed
//
// one word passes through accept, scale, 32 remainder steps (one dividend
// bit a cycle through the subtractor), then load of the output register.
// a full 32-bit span skips the remainder loop.
// reset and every seed write run a splitmix32 pass (add, multiply, xorshift, multiply,
// store per state word, one shared 32x32 multiplier); s_axis and cfg are not ready then.
// s_axis is taken again while a finished word waits on m_axis; a seed write goes first.
module xoshiro128ss_bounded_random (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // min_value, max_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // value
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data        // seed
);
  import xsbr_pkg::*;

  state_t state, state_next;

  logic [WordW-1:0] gen_state [4];
  logic [WordW-1:0] acc;
  logic [WordW-1:0] mix;
  logic [1:0]       idx;

  logic [WordW-1:0] lo;
  logic [WordW-1:0] span;
  logic [WordW-1:0] word;
  logic [WordW-1:0] rem;
  logic [4:0]       bit_cnt;

  logic             in_acc;
  logic             cfg_acc;
  logic             out_free;

  logic signed [WordW-1:0] in_min, in_max;
  logic [WordW-1:0] b_lo, b_hi;
  logic [WordW-1:0] acc_sum;
  logic [WordW-1:0] mul_k;
  logic [WordW-1:0] product;
  logic [WordW-1:0] s1x5;
  logic [WordW-1:0] t9;
  logic [WordW-1:0] s0n, s1n, s2n, s3n, s3x;
  logic [WordW:0]   trial;
  logic [WordW:0]   trial_diff;

  assign s_axis_tready = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready     = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_acc       = cfg_valid && cfg_ready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign in_min  = s_axis_tdata[31:0];
  assign in_max  = s_axis_tdata[63:32];
  assign b_lo    = (in_min > in_max) ? in_max : in_min;
  assign b_hi    = (in_min > in_max) ? in_min : in_max;

  assign acc_sum = acc + MIX_GAMMA;
  assign mul_k   = (state == S_SEED_MULA) ? MIX_MUL_A : MIX_MUL_B;
  assign product = mix * mul_k;

  assign s1x5 = gen_state[1] + (gen_state[1] << 2);
  assign t9   = gen_state[1] << 9;
  assign s2n  = gen_state[2] ^ gen_state[0];
  assign s3x  = gen_state[3] ^ gen_state[1];
  assign s1n  = gen_state[1] ^ s2n;
  assign s0n  = gen_state[0] ^ s3x;
  assign s3n  = {s3x[WordW-12:0], s3x[WordW-1:WordW-11]};

  assign trial      = {rem, word[WordW-1]};
  assign trial_diff = trial - {1'b0, span};

  always_comb begin
    state_next = state;
    unique case (state)
      S_SEED_ADD:   state_next = S_SEED_MULA;
      S_SEED_MULA:  state_next = S_SEED_XOR;
      S_SEED_XOR:   state_next = S_SEED_MULB;
      S_SEED_MULB:  state_next = S_SEED_STORE;
      S_SEED_STORE: state_next = (idx == 2'd3) ? S_IDLE : S_SEED_ADD;
      S_IDLE: begin
        if (cfg_acc) begin
          state_next = S_SEED_ADD;
        end else if (in_acc) begin
          state_next = S_SCALE;
        end
      end
      S_SCALE:      state_next = (span == '0) ? S_FINISH : S_REM;
      S_REM:        state_next = (bit_cnt == '0) ? S_FINISH : S_REM;
      S_FINISH:     state_next = out_free ? S_IDLE : S_FINISH;
      default:      state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SEED_ADD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      idx <= '0;
    end else begin
      case (state) inside
        S_SEED_ADD: begin
          acc <= acc_sum;
          mix <= acc_sum ^ (acc_sum >> 16);
        end
        S_SEED_MULA, S_SEED_MULB: mix <= product;
        S_SEED_XOR:               mix <= mix ^ (mix >> 13);
        S_SEED_STORE: begin
          gen_state[idx] <= mix ^ (mix >> 16);
          idx            <= idx + 2'd1;
        end
        S_IDLE: begin
          if (cfg_acc) begin
            acc <= cfg_data;
            idx <= '0;
          end else if (in_acc) begin
            lo           <= b_lo;
            span         <= b_hi - b_lo + 32'd1;
            word         <= {s1x5[WordW-8:0], s1x5[WordW-1:WordW-7]};
            gen_state[0] <= s0n;
            gen_state[1] <= s1n;
            gen_state[2] <= s2n ^ t9;
            gen_state[3] <= s3n;
          end
        end
        S_SCALE: begin
          bit_cnt <= 5'd31;
          if (span == '0) begin
            rem <= word + (word << 3);
          end else begin
            rem  <= '0;
            word <= word + (word << 3);
          end
        end
        S_REM: begin
          // restoring step: bring in one dividend bit
          rem     <= trial_diff[WordW] ? trial[WordW-1:0] : trial_diff[WordW-1:0];
          word    <= word << 1;
          bit_cnt <= bit_cnt - 5'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == S_FINISH && out_free) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= lo + rem;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  a_in_cfg_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(in_acc && cfg_acc))
    else $error("input word and seed write taken together");

  a_accept_to_scale: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == S_SCALE))
    else $error("accepted word did not move to scale step");

  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == S_FINISH))
    else $error("output word appeared outside finish step");

  a_rem_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_REM) |-> (rem < span))
    else $error("partial remainder not below span");

endmodule
